>>> hdl/brf_pkg.sv
// Shared types and codes for the byte ring FIFO.
package brf_pkg;

  localparam logic [2:0] FN_PUSH  = 3'd0;
  localparam logic [2:0] FN_POP   = 3'd1;
  localparam logic [2:0] FN_PEEK  = 3'd2;
  localparam logic [2:0] FN_BPOP  = 3'd3;
  localparam logic [2:0] FN_BPEEK = 3'd4;
  localparam logic [2:0] FN_DROP  = 3'd5;
  localparam logic [2:0] FN_CLEAR = 3'd6;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_UNF = 2'd2;

  typedef enum logic [2:0] {
    K_NOP,
    K_PUSH,
    K_READ,
    K_DROP,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data;
    logic [6:0] length;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last;
    logic [1:0] status;
    logic [6:0] transferred;
    logic [6:0] used;
    logic [6:0] free_slots;
    logic       empty_res;
    logic       full_res;
  } out_t;

  // Decoded command as queued between front and back.
  typedef struct packed {
    kind_t      kind;
    logic       consume;
    logic [7:0] data;
    logic [6:0] req_len;
  } cmd_t;

endpackage

>>> hdl/brf_front.sv
// Command intake: decodes func and holds decoded commands in a two-entry queue.
module brf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  brf_pkg::in_t  in_cmd,
  output logic          q_valid,
  output brf_pkg::cmd_t q_cmd,
  input  logic          q_take
);

  brf_pkg::cmd_t q_mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic          pop;
  brf_pkg::cmd_t dec;

  // classify
  always_comb begin
    dec.kind    = brf_pkg::K_NOP;
    dec.consume = 1'b0;
    dec.data    = in_cmd.data;
    dec.req_len = in_cmd.length;
    case (in_cmd.func)
      brf_pkg::FN_PUSH: dec.kind = brf_pkg::K_PUSH;
      brf_pkg::FN_POP: begin
        dec.kind    = brf_pkg::K_READ;
        dec.consume = 1'b1;
        dec.req_len = 7'd1;
      end
      brf_pkg::FN_PEEK: begin
        dec.kind    = brf_pkg::K_READ;
        dec.req_len = 7'd1;
      end
      brf_pkg::FN_BPOP: begin
        dec.kind    = brf_pkg::K_READ;
        dec.consume = 1'b1;
      end
      brf_pkg::FN_BPEEK: dec.kind = brf_pkg::K_READ;
      brf_pkg::FN_DROP:  dec.kind = brf_pkg::K_DROP;
      brf_pkg::FN_CLEAR: dec.kind = brf_pkg::K_CLEAR;
      default:           dec.kind = brf_pkg::K_NOP;
    endcase
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_take && q_valid;
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hdl/brf_back.sv
// Execution side: ring store, pointers, fill count and result generation.
module brf_back #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata,
  input  logic          q_valid,
  input  brf_pkg::cmd_t q_cmd,
  output logic          q_take,
  output logic          out_valid,
  output brf_pkg::out_t out_res
);

  localparam int         AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [6:0] DEPTH_W = 7'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [6:0]    fill_r, fill_nxt;
  logic [6:0]    cap_r, cap_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [6:0]    n_r, n_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          consume_r, consume_nxt;
  logic          out_valid_r, out_valid_nxt;
  brf_pkg::out_t out_r, out_nxt;

  logic [7:0]    mem_r [DEPTH];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic [6:0]    n_c;
  logic [1:0]    st_c;
  logic [AW-1:0] pos_inc;
  logic [6:0]    cnt_inc;
  logic [6:0]    fill_b;

  // (a + b) mod cap, valid for a < cap and b <= cap
  function automatic logic [AW-1:0] wrap(input logic [6:0] s, input logic [6:0] cap);
    logic [6:0] r;
    r = (s >= cap) ? (s - cap) : s;
    return r[AW-1:0];
  endfunction

  function automatic brf_pkg::out_t mk(input logic [7:0] b, input logic lst,
                                       input logic [1:0] st, input logic [6:0] moved,
                                       input logic [6:0] fill, input logic [6:0] cap);
    brf_pkg::out_t o;
    o.byte_out    = b;
    o.last        = lst;
    o.status      = st;
    o.transferred = moved;
    o.used        = fill;
    o.free_slots  = cap - fill;
    o.empty_res   = (fill == 7'd0);
    o.full_res    = (fill == cap);
    return o;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    cap_nxt       = cap_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    stat_nxt      = stat_r;
    consume_nxt   = consume_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    q_take        = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = wrap(7'(head_r) + fill_r, cap_r);
    rd_addr       = pos_r;
    n_c           = (q_cmd.req_len < fill_r) ? q_cmd.req_len : fill_r;
    st_c          = (q_cmd.req_len > fill_r) ? brf_pkg::ST_UNF : brf_pkg::ST_OK;
    pos_inc       = wrap(7'(pos_r) + 7'd1, cap_r);
    cnt_inc       = cnt_r + 7'd1;
    fill_b        = consume_r ? (fill_r - 7'd1) : fill_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_take        = 1'b1;
          out_valid_nxt = 1'b1;
          case (q_cmd.kind)
            brf_pkg::K_PUSH: begin
              if (fill_r >= cap_r) begin
                out_nxt = mk(8'd0, 1'b1, brf_pkg::ST_OVF, 7'd0, fill_r, cap_r);
              end else begin
                wr_en    = 1'b1;
                fill_nxt = fill_r + 7'd1;
                out_nxt  = mk(8'd0, 1'b1, brf_pkg::ST_OK, 7'd1, fill_r + 7'd1, cap_r);
              end
            end
            brf_pkg::K_READ: begin
              if (q_cmd.req_len == 7'd0) begin
                out_nxt = mk(8'd0, 1'b1, brf_pkg::ST_OK, 7'd0, fill_r, cap_r);
              end else if (n_c == 7'd0) begin
                out_nxt = mk(8'd0, 1'b1, st_c, 7'd0, fill_r, cap_r);
              end else begin
                // first byte comes out of the store next cycle
                out_valid_nxt = 1'b0;
                n_nxt         = n_c;
                stat_nxt      = st_c;
                consume_nxt   = q_cmd.consume;
                pos_nxt       = head_r;
                cnt_nxt       = 7'd0;
                rd_addr       = head_r;
                state_nxt     = S_BURST;
              end
            end
            brf_pkg::K_DROP: begin
              head_nxt = wrap(7'(head_r) + n_c, cap_r);
              fill_nxt = fill_r - n_c;
              out_nxt  = mk(8'd0, 1'b1, st_c, n_c, fill_r - n_c, cap_r);
            end
            brf_pkg::K_CLEAR: begin
              head_nxt = '0;
              fill_nxt = 7'd0;
              out_nxt  = mk(8'd0, 1'b1, brf_pkg::ST_OK, 7'd0, 7'd0, cap_r);
            end
            default: begin
              out_nxt = mk(8'd0, 1'b1, brf_pkg::ST_OK, 7'd0, fill_r, cap_r);
            end
          endcase
        end
      end
      S_BURST: begin
        out_valid_nxt = 1'b1;
        out_nxt       = mk(rd_data_r, cnt_inc == n_r, stat_r, cnt_inc, fill_b, cap_r);
        pos_nxt       = pos_inc;
        rd_addr       = pos_inc;
        cnt_nxt       = cnt_inc;
        fill_nxt      = fill_b;
        if (consume_r) begin
          head_nxt = pos_inc;
        end
        if (cnt_inc == n_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // capacity write also empties the ring; the user must issue it only while idle, the block does not enforce it
    if (cfg_we) begin
      if (cfg_wdata == 7'd0) begin
        cap_nxt = 7'd1;
      end else if (cfg_wdata > DEPTH_W) begin
        cap_nxt = DEPTH_W;
      end else begin
        cap_nxt = cfg_wdata;
      end
      head_nxt = '0;
      fill_nxt = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= q_cmd.data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= 7'd0;
      cap_r       <= DEPTH_W;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r     <= pos_nxt;
    cnt_r     <= cnt_nxt;
    n_r       <= n_nxt;
    stat_r    <= stat_nxt;
    consume_r <= consume_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

>>> hdl/byte_ring_fifo_unit.sv
// Top level of the byte ring FIFO: command intake, queue and execution engine.
// A command beat is taken when start is high and busy is low; it lands in a
// two-entry queue, so busy rises only when two commands are waiting. The
// execution engine takes one queued command per cycle for push, drop, clear,
// idle codes and for any read that moves no byte: one result, registered, on
// the cycle after the command leaves the queue. A pop, peek or burst that
// moves n bytes first addresses the ring store (its read port is registered)
// and then emits one byte per cycle, with last on the final byte; the bursts
// are the rate limit. Results appear on out_res for exactly one cycle,
// flagged by out_valid, and cannot be held off. The capacity register
// (cfg_we / cfg_wdata) clamps 0 to 1 and anything above DEPTH to DEPTH, and a
// write also empties the FIFO; write it only when no command is queued or in
// progress. The store itself is never cleared: only written entries are ever
// read back.
module byte_ring_fifo_unit #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  brf_pkg::in_t  in_cmd,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata,
  output logic          out_valid,
  output brf_pkg::out_t out_res
);

  logic          q_valid;
  logic          q_take;
  brf_pkg::cmd_t q_cmd;

  brf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_cmd  (in_cmd),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_take  (q_take)
  );

  brf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // burst bytes come out back to back until the last beat
  a_burst_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.last |=> out_valid)
    else $error("burst beat gap");

  // fill flags agree with the reported counts
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.empty_res == (out_res.used == 7'd0)) &&
                  (!out_res.full_res || out_res.free_slots == 7'd0))
    else $error("fill flags inconsistent");

  // an overflowed push moves nothing and leaves the FIFO full
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status == brf_pkg::ST_OVF |->
      out_res.transferred == 7'd0 && out_res.full_res)
    else $error("overflow result inconsistent");

  // engine only pulls from a non-empty queue
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("take from empty queue");

endmodule

>>> verif/brf_ring_checker.sv
// Checker for the byte ring FIFO: mirrors the ring, predicts each result beat, compares.
module brf_ring_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  brf_pkg::in_t  in_cmd,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata,
  input  logic          out_valid,
  input  brf_pkg::out_t out_res,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = 64;

  logic [7:0]    ring_mem [RING_DEPTH];
  int unsigned   ring_head;
  int unsigned   ring_fill;
  int unsigned   ring_cap;
  brf_pkg::out_t awaited_beats [$];

  function automatic int unsigned ring_advance(int unsigned pos, int unsigned n);
    int unsigned s;
    s = pos + n;
    if (s >= ring_cap) s -= ring_cap;
    return s;
  endfunction

  // Result beat as it must look with the fill state now held.
  function automatic void await_beat(logic [7:0] b, logic lst, logic [1:0] st,
                                     int unsigned moved);
    brf_pkg::out_t r;
    r.byte_out    = b;
    r.last        = lst;
    r.status      = st;
    r.transferred = 7'(moved);
    r.used        = 7'(ring_fill);
    r.free_slots  = 7'(ring_cap - ring_fill);
    r.empty_res   = (ring_fill == 0);
    r.full_res    = (ring_fill == ring_cap);
    awaited_beats.push_back(r);
  endfunction

  function automatic void ring_apply_cmd(brf_pkg::in_t c);
    int unsigned req;
    int unsigned n;
    int unsigned pos;
    logic [1:0]  st;
    logic [7:0]  b;
    req = 32'(c.length);
    n   = (req < ring_fill) ? req : ring_fill;
    st  = (req > ring_fill) ? brf_pkg::ST_UNF : brf_pkg::ST_OK;
    case (c.func)
      brf_pkg::FN_PUSH: begin
        if (ring_fill >= ring_cap) begin
          await_beat(8'h00, 1'b1, brf_pkg::ST_OVF, 0);
        end else begin
          ring_mem[ring_advance(ring_head, ring_fill)] = c.data;
          ring_fill++;
          await_beat(8'h00, 1'b1, brf_pkg::ST_OK, 1);
        end
      end
      brf_pkg::FN_POP, brf_pkg::FN_PEEK: begin
        if (ring_fill == 0) begin
          await_beat(8'h00, 1'b1, brf_pkg::ST_UNF, 0);
        end else begin
          b = ring_mem[ring_head];
          if (c.func == brf_pkg::FN_POP) begin
            ring_head = ring_advance(ring_head, 1);
            ring_fill--;
          end
          await_beat(b, 1'b1, brf_pkg::ST_OK, 1);
        end
      end
      brf_pkg::FN_BPOP, brf_pkg::FN_BPEEK: begin
        if (req == 0) begin
          await_beat(8'h00, 1'b1, brf_pkg::ST_OK, 0);
        end else if (n == 0) begin
          await_beat(8'h00, 1'b1, st, 0);
        end else begin
          pos = ring_head;
          for (int unsigned k = 0; k < n; k++) begin
            b   = ring_mem[pos];
            pos = ring_advance(pos, 1);
            if (c.func == brf_pkg::FN_BPOP) begin
              ring_head = pos;
              ring_fill--;
            end
            await_beat(b, (k + 1 == n), st, k + 1);
          end
        end
      end
      brf_pkg::FN_DROP: begin
        ring_head = ring_advance(ring_head, n);
        ring_fill -= n;
        await_beat(8'h00, 1'b1, st, n);
      end
      brf_pkg::FN_CLEAR: begin
        ring_head = 0;
        ring_fill = 0;
        await_beat(8'h00, 1'b1, brf_pkg::ST_OK, 0);
      end
      default: await_beat(8'h00, 1'b1, brf_pkg::ST_OK, 0);
    endcase
  endfunction

  function automatic void check_field(string what, logic [7:0] exp, logic [7:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, what, exp, act);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    brf_pkg::out_t e;
    int unsigned   v;
    if (!rst_n) begin
      ring_head  = 0;
      ring_fill  = 0;
      ring_cap   = RING_DEPTH;
      fail_count = 0;
      awaited_beats.delete();
    end else begin
      if (out_valid) begin
        if (awaited_beats.size() == 0) begin
          $display("%0t: result beat with none expected, expected none actual %h",
                   $realtime, out_res);
          fail_count++;
        end else begin
          e = awaited_beats.pop_front();
          check_field("byte_out",    e.byte_out,        out_res.byte_out);
          check_field("last",        8'(e.last),        8'(out_res.last));
          check_field("status",      8'(e.status),      8'(out_res.status));
          check_field("transferred", 8'(e.transferred), 8'(out_res.transferred));
          check_field("used",        8'(e.used),        8'(out_res.used));
          check_field("free_slots",  8'(e.free_slots),  8'(out_res.free_slots));
          check_field("empty_res",   8'(e.empty_res),   8'(out_res.empty_res));
          check_field("full_res",    8'(e.full_res),    8'(out_res.full_res));
        end
      end
      // capacity write clamps and empties the ring
      if (cfg_we) begin
        v = 32'(cfg_wdata);
        if (v == 0) v = 1;
        if (v > RING_DEPTH) v = RING_DEPTH;
        ring_cap  = v;
        ring_head = 0;
        ring_fill = 0;
      end
      if (start && !busy)
        ring_apply_cmd(in_cmd);
    end
    pending <= awaited_beats.size();
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for the byte ring FIFO: clock, reset, command stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // func code 7 is not an operation; the block must answer it with a plain ok beat
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          start     = 1'b0;
  brf_pkg::in_t  in_cmd    = '0;
  logic          cfg_we    = 1'b0;
  logic [6:0]    cfg_wdata = 7'd64;
  logic          busy;
  logic          out_valid;
  brf_pkg::out_t out_res;
  int            fail_count;
  int            pending;

  int          send_idle_pct = 0;   // chance in 100 that the sender idles in a given cycle
  int          cap_now       = 64;  // capacity in force, after clamping
  int unsigned cycle_count   = 0;

  always #5 clk = ~clk;

  byte_ring_fifo_unit #(.DEPTH(64)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  brf_ring_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Hard stop: the slowest legal run is far below this (about 160 commands, plus
  // sender idle cycles and short settle tails).
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // One command beat. Start stays high across back-to-back beats; it only drops
  // for random sender idle cycles. Returns on the edge that took the beat.
  task automatic issue_cmd(input logic [2:0] fn, input logic [7:0] d,
                           input logic [6:0] len);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_cmd <= '{func: fn, data: d, length: len};
    do @(posedge clk); while (busy);
  endtask

  // Let every outstanding beat come back, then a short tail for the engine to go
  // quiet. Capacity writes are only legal after this.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_now = (v == 0) ? 1 : ((v > 64) ? 64 : int'(v));
    @(posedge clk);
  endtask

  // Random traffic. Push runs sized around the capacity drive the ring to full,
  // overflow and wrap; the rest mixes reads, bursts, drops, clears and the unused
  // code. Lengths stay mostly small so bursts end short of or just past the fill.
  task automatic run_phase(input int idle_pct, input int target);
    int         issued;
    int         sel;
    int         run;
    logic [6:0] len;
    issued        = 0;
    send_idle_pct = idle_pct;
    while (issued < target) begin
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 10));
      if (sel < 12) begin
        run = $urandom_range(1, cap_now + 2);
        if (run > target - issued) run = target - issued;
        repeat (run) issue_cmd(brf_pkg::FN_PUSH, 8'($urandom), 7'($urandom));
        issued += run;
      end else begin
        if (sel < 45)      issue_cmd(brf_pkg::FN_PUSH,  8'($urandom), len);
        else if (sel < 56) issue_cmd(brf_pkg::FN_POP,   8'($urandom), len);
        else if (sel < 61) issue_cmd(brf_pkg::FN_PEEK,  8'($urandom), len);
        else if (sel < 73) issue_cmd(brf_pkg::FN_BPOP,  8'($urandom), len);
        else if (sel < 81) issue_cmd(brf_pkg::FN_BPEEK, 8'($urandom), len);
        else if (sel < 90) issue_cmd(brf_pkg::FN_DROP,  8'($urandom), len);
        else if (sel < 93) issue_cmd(brf_pkg::FN_CLEAR, 8'($urandom), len);
        else if (sel < 96) issue_cmd(FN_UNUSED,         8'($urandom), len);
        else               issue_cmd(brf_pkg::FN_POP,   8'($urandom), len);
        issued++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads, bursts and drops on an empty ring (underflow, zero length)
    issue_cmd(brf_pkg::FN_POP,   8'h00, 7'd0);
    issue_cmd(brf_pkg::FN_PEEK,  8'hFF, 7'd127);
    issue_cmd(brf_pkg::FN_BPOP,  8'h00, 7'd5);
    issue_cmd(brf_pkg::FN_BPEEK, 8'h00, 7'd0);
    issue_cmd(brf_pkg::FN_DROP,  8'h00, 7'd0);
    issue_cmd(brf_pkg::FN_DROP,  8'h00, 7'd3);
    // byte extremes in, then every read form on a partly filled ring
    issue_cmd(brf_pkg::FN_PUSH,  8'h00, 7'd0);
    issue_cmd(brf_pkg::FN_PUSH,  8'hFF, 7'd127);
    issue_cmd(brf_pkg::FN_PUSH,  8'hA5, 7'd0);
    issue_cmd(brf_pkg::FN_PUSH,  8'h5A, 7'd0);
    issue_cmd(brf_pkg::FN_PUSH,  8'h3C, 7'd0);
    issue_cmd(brf_pkg::FN_PEEK,  8'h00, 7'd0);
    issue_cmd(brf_pkg::FN_POP,   8'h00, 7'd0);
    issue_cmd(brf_pkg::FN_BPEEK, 8'h00, 7'd2);
    issue_cmd(brf_pkg::FN_BPEEK, 8'h00, 7'd10);   // short burst: underflow on every beat
    issue_cmd(brf_pkg::FN_BPOP,  8'h00, 7'd2);
    issue_cmd(brf_pkg::FN_DROP,  8'h00, 7'd0);
    issue_cmd(brf_pkg::FN_DROP,  8'h00, 7'd100);  // asks for more than held: empties
    issue_cmd(FN_UNUSED,         8'hFF, 7'd127);
    issue_cmd(brf_pkg::FN_PUSH,  8'h11, 7'd0);
    issue_cmd(brf_pkg::FN_CLEAR, 8'h00, 7'd0);
    settle();

    // Capacity written as 0 acts as one entry: full, overflow, single-byte wrap
    write_capacity(7'd0);
    issue_cmd(brf_pkg::FN_PUSH,  8'h77, 7'd0);
    issue_cmd(brf_pkg::FN_PUSH,  8'h88, 7'd0);    // ring already full
    issue_cmd(brf_pkg::FN_PEEK,  8'h00, 7'd0);
    issue_cmd(brf_pkg::FN_BPOP,  8'h00, 7'd127);
    issue_cmd(brf_pkg::FN_PUSH,  8'h99, 7'd0);
    issue_cmd(brf_pkg::FN_DROP,  8'h00, 7'd1);
    settle();

    // All ones clamps to the full depth
    write_capacity(7'd127);
    issue_cmd(brf_pkg::FN_PUSH,  8'h42, 7'd0);
    settle();

    // Random phases: sender idles about a quarter of cycles, then about half, then never
    write_capacity(7'($urandom_range(3, 16)));
    run_phase(28, 44);
    settle();
    write_capacity(7'd64);
    run_phase(48, 44);
    settle();
    write_capacity(7'($urandom_range(17, 63)));
    run_phase(0, 44);
    settle();

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
